// ===== hdl/sls_pkg.sv =====
// status led sequencer package: status codes, colour constants, register map
// and the configuration bundle shared by the sequencer modules
// no dependencies
package sls_pkg;

    // status codes carried on the request channel
    localparam logic [2:0] ST_OFF        = 3'd0;
    localparam logic [2:0] ST_STARTUP    = 3'd1;
    localparam logic [2:0] ST_DISABLED   = 3'd2;
    localparam logic [2:0] ST_CONNECTING = 3'd3;
    localparam logic [2:0] ST_CONNECTED  = 3'd4;
    localparam logic [2:0] ST_FAILED     = 3'd5;

    // fixed colours, red in the top byte
    localparam logic [23:0] RGB_OFF    = 24'h000000;
    localparam logic [23:0] RGB_PURPLE = 24'h800080;
    localparam logic [23:0] RGB_RED    = 24'hFF0000;
    localparam logic [23:0] RGB_YELLOW = 24'hFFFF00;
    localparam logic [23:0] RGB_GREEN  = 24'h00FF00;

    // register map, word index
    localparam logic [1:0] REG_BLINK_HALF    = 2'd0;
    localparam logic [1:0] REG_RAINBOW_DELAY = 2'd1;
    localparam logic [1:0] REG_RAINBOW_STEP  = 2'd2;

    localparam logic [15:0] BLINK_HALF_RST    = 16'd500;
    localparam logic [15:0] RAINBOW_DELAY_RST = 16'd5000;
    localparam logic [9:0]  RAINBOW_STEP_RST  = 10'd20;

    typedef struct packed {
        logic [15:0] blink_half_period_ms;
        logic [15:0] rainbow_delay_ms;
        logic [9:0]  rainbow_step_ms;
    } cfg_t;

endpackage

// ===== hdl/sls_cfg.sv =====
// status led sequencer configuration registers behind a simple apb port
// depends on sls_pkg
module sls_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output sls_pkg::cfg_t     cfg
);
    import sls_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign wr_en = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_BLINK_HALF:    cfg_next.blink_half_period_ms = pwdata[15:0];
                REG_RAINBOW_DELAY: cfg_next.rainbow_delay_ms     = pwdata[15:0];
                REG_RAINBOW_STEP:  cfg_next.rainbow_step_ms      = pwdata[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_half_period_ms <= BLINK_HALF_RST;
            cfg_reg.rainbow_delay_ms     <= RAINBOW_DELAY_RST;
            cfg_reg.rainbow_step_ms      <= RAINBOW_STEP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BLINK_HALF:    prdata = {16'd0, cfg_reg.blink_half_period_ms};
            REG_RAINBOW_DELAY: prdata = {16'd0, cfg_reg.rainbow_delay_ms};
            REG_RAINBOW_STEP:  prdata = {22'd0, cfg_reg.rainbow_step_ms};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/sls_hue.sv =====
// status led sequencer hue wheel: hue index to rgb at full saturation and value
// no dependencies
module sls_hue (
    input  logic [7:0]  hue_idx,
    output logic [23:0] color
);

    // (255 * x) >> 8 without a multiplier
    function automatic logic [7:0] scale255(input logic [7:0] x);
        logic [15:0] prod;
        prod = {x, 8'h00} - {8'h00, x};
        return prod[15:8];
    endfunction

    logic [10:0] hue6;
    logic [2:0]  region;
    logic [7:0]  frac;
    logic [7:0]  q_val;
    logic [7:0]  t_val;

    // six sectors of 256 across the wheel
    assign hue6   = {1'b0, hue_idx, 2'b00} + {2'b00, hue_idx, 1'b0};
    assign region = hue6[10:8];
    assign frac   = hue6[7:0];
    assign q_val  = scale255(8'hFF - scale255(frac));
    assign t_val  = scale255(8'hFF - scale255(8'hFF - frac));

    always_comb begin
        case (region)
            3'd0:    color = {8'hFF, t_val, 8'h00};
            3'd1:    color = {q_val, 8'hFF, 8'h00};
            3'd2:    color = {8'h00, 8'hFF, t_val};
            3'd3:    color = {8'h00, q_val, 8'hFF};
            3'd4:    color = {t_val, 8'h00, 8'hFF};
            default: color = {8'hFF, 8'h00, q_val};
        endcase
    end

endmodule

// ===== hdl/sls_core.sv =====
// status led sequencer state update: status, blink, green delay and rainbow timers
// depends on sls_pkg and sls_hue
module sls_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sls_pkg::cfg_t     cfg,
    input  logic              go,
    input  logic              cmd,
    input  logic [2:0]        status,
    output logic              res_valid,
    output logic [23:0]       res_color
);
    import sls_pkg::*;

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [2:0]            status_reg,  status_next;
    logic                  blink_on_reg, blink_on_next;
    logic [TIMER_BITS-1:0] blink_el_reg, blink_el_next;
    logic                  green_run_reg, green_run_next;
    logic [TIMER_BITS-1:0] green_el_reg, green_el_next;
    logic                  rainbow_reg, rainbow_next;
    logic [TIMER_BITS-1:0] rain_el_reg, rain_el_next;
    logic [7:0]            hue_reg, hue_next;

    logic [TIMER_BITS-1:0] blink_inc, green_inc, rain_inc;
    logic [7:0]            hue_adv;
    logic [23:0]           hue_color;

    // saturating increments
    assign blink_inc = (&blink_el_reg) ? blink_el_reg : blink_el_reg + 1'b1;
    assign green_inc = (&green_el_reg) ? green_el_reg : green_el_reg + 1'b1;
    assign rain_inc  = (&rain_el_reg)  ? rain_el_reg  : rain_el_reg + 1'b1;

    // hue after the next advance; a rainbow start restarts the wheel at zero
    assign hue_adv = rainbow_reg ? hue_reg + 8'd1 : 8'd1;

    sls_hue u_hue (
        .hue_idx (hue_adv),
        .color   (hue_color)
    );

    always_comb begin
        status_next    = status_reg;
        blink_on_next  = blink_on_reg;
        blink_el_next  = blink_el_reg;
        green_run_next = green_run_reg;
        green_el_next  = green_el_reg;
        rainbow_next   = rainbow_reg;
        rain_el_next   = rain_el_reg;
        hue_next       = hue_reg;
        res_valid      = 1'b0;
        res_color      = RGB_OFF;

        if (cmd) begin
            status_next = status;
            if (status != ST_CONNECTED) begin
                rainbow_next   = 1'b0;
                green_run_next = 1'b0;
                green_el_next  = '0;
            end
            case (status)
                ST_OFF: begin
                    res_valid = 1'b1;
                    res_color = RGB_OFF;
                end
                ST_STARTUP: begin
                    res_valid = 1'b1;
                    res_color = RGB_PURPLE;
                end
                ST_DISABLED, ST_FAILED: begin
                    res_valid = 1'b1;
                    res_color = RGB_RED;
                end
                ST_CONNECTING: begin
                    blink_on_next = 1'b1;
                    blink_el_next = '0;
                    res_valid     = 1'b1;
                    res_color     = RGB_YELLOW;
                end
                ST_CONNECTED: begin
                    // green timer keeps running if already started
                    if (!green_run_reg) begin
                        green_run_next = 1'b1;
                        green_el_next  = '0;
                    end
                    res_valid = 1'b1;
                    res_color = RGB_GREEN;
                end
                default: begin
                    // unknown status: stored, no colour written
                    res_valid = 1'b0;
                end
            endcase
        end else if (status_reg == ST_CONNECTING) begin
            blink_el_next = blink_inc;
            if (CMP_W'(blink_inc) >= CMP_W'(cfg.blink_half_period_ms)) begin
                blink_el_next = '0;
                blink_on_next = !blink_on_reg;
                res_valid     = 1'b1;
                res_color     = blink_on_reg ? RGB_OFF : RGB_YELLOW;
            end
        end else if (status_reg == ST_CONNECTED) begin
            if (rainbow_reg) begin
                rain_el_next = rain_inc;
            end else if (green_run_reg) begin
                green_el_next = green_inc;
                if (CMP_W'(green_inc) >= CMP_W'(cfg.rainbow_delay_ms)) begin
                    rainbow_next = 1'b1;
                    hue_next     = 8'd0;
                    rain_el_next = '0;
                end
            end
            if (rainbow_next &&
                (CMP_W'(rain_el_next) >= CMP_W'(cfg.rainbow_step_ms))) begin
                rain_el_next = '0;
                hue_next     = hue_next + 8'd1;
                res_valid    = 1'b1;
                res_color    = hue_color;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg    <= ST_OFF;
            blink_on_reg  <= 1'b0;
            blink_el_reg  <= '0;
            green_run_reg <= 1'b0;
            green_el_reg  <= '0;
            rainbow_reg   <= 1'b0;
            rain_el_reg   <= '0;
            hue_reg       <= 8'd0;
        end else if (go) begin
            status_reg    <= status_next;
            blink_on_reg  <= blink_on_next;
            blink_el_reg  <= blink_el_next;
            green_run_reg <= green_run_next;
            green_el_reg  <= green_el_next;
            rainbow_reg   <= rainbow_next;
            rain_el_reg   <= rain_el_next;
            hue_reg       <= hue_next;
        end
    end

`ifndef SYNTHESIS
    a_rainbow_needs_connected: assert property (@(posedge aclk) disable iff (!aresetn)
        rainbow_reg |-> (status_reg == ST_CONNECTED))
        else $error("rainbow mode outside connected status");

    a_rainbow_needs_green: assert property (@(posedge aclk) disable iff (!aresetn)
        rainbow_reg |-> green_run_reg)
        else $error("rainbow mode without green timer");

    a_leave_connected_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && cmd && (status != ST_CONNECTED)) |=> (!rainbow_reg && !green_run_reg))
        else $error("status change left rainbow or green timer running");
`endif

endmodule

// ===== hdl/status_led_sequencer.sv =====
// status led sequencer top level: request register, state update, result register
// depends on sls_pkg, sls_cfg and sls_core
//
// Drives one status LED from a stream of requests. Each request is either a
// one-millisecond tick (s_tuser = 0) or a set-status command (s_tuser = 1, new
// status in s_tdata). A command writes the status's fixed colour straight away;
// unknown status codes 6 and 7 are stored but write nothing. While connecting,
// ticks toggle yellow and off every blink_half_period_ms ticks. While connected,
// green holds for rainbow_delay_ms ticks, then the hue steps once every
// rainbow_step_ms ticks round a 256-entry wheel. A result (m_tdata = colour,
// red in bits 23:16) comes out only when the colour is written, so many ticks
// produce none. One request is accepted every clock cycle while the result
// channel is not stalled; a request's result passes the request register and
// the single-pass update logic into the result register, which drives
// m_tvalid. A stalled result holds its register while the next request
// waits in the request register. Timers are TIMER_BITS wide and saturate.
// Registers: 0x0 blink half period, 0x4 rainbow delay, 0x8 rainbow step;
// write them only while the block is idle.
module status_led_sequencer #(
    parameter int TIMER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] status, [7:3] zero
    input  logic        s_tuser,   // [0] cmd
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] color
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sls_pkg::*;

    cfg_t        cfg;
    logic        in_valid_reg, in_valid_next;
    logic        in_cmd_reg;
    logic [2:0]  in_status_reg;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_color_reg;
    logic        advance;
    logic        res_valid;
    logic [23:0] res_color;

    assign pready = 1'b1;

    sls_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // the held request moves on once the result register is free or emptying
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sls_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .go        (advance),
        .cmd       (in_cmd_reg),
        .status    (in_status_reg),
        .res_valid (res_valid),
        .res_color (res_color)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg    <= s_tuser;
            in_status_reg <= s_tdata[2:0];
        end
        if (advance && res_valid) begin
            out_color_reg <= res_color;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid) |=> out_valid_reg)
        else $error("produced colour not held in result register");

    a_stalled_request_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("request dropped while result stalled");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("update logic ran into a stalled result");
`endif

endmodule
